FILE: hdl/wtsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_pkg
// shared types and constants of the world to screen projection block
// ----------------------------------------------------------------------------
package wtsp_pkg;

    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1080;

    localparam int COEF_W   = 32;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int FRAC_W   = 16;
    // clip coordinate: three floored products plus a translation term
    localparam int CLIP_W   = 50;
    localparam int DIM_MAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int DIM_W    = $clog2(DIM_MAX + 1);
    localparam int MAG_W    = CLIP_W - 1 + DIM_W;
    localparam int NUM_W    = MAG_W + 16;
    localparam int CAP_SH   = 20;
    localparam int QUO_W    = CAP_SH + 16;
    localparam int REM_W    = CLIP_W;
    localparam int CMP_W    = CLIP_W + CAP_SH;
    localparam int SUM_W    = QUO_W + 3;
    localparam int OUT_W    = 32;

    // 0.1 in q16.16
    localparam logic signed [CLIP_W-1:0] W_MIN = CLIP_W'(6554);

    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_AB = 4'd0,
        REG_ROW0_CD = 4'd1,
        REG_ROW1_AB = 4'd2,
        REG_ROW1_CD = 4'd3,
        REG_ROW2_AB = 4'd4,
        REG_ROW2_CD = 4'd5,
        REG_ROW3_AB = 4'd6,
        REG_ROW3_CD = 4'd7
    } t_reg_idx;

    // clip coordinates of one point, as handed from front to back
    typedef struct packed {
        logic                     vis;
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cw;
    } t_clip;

endpackage

FILE: hdl/wtsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_front
// matrix rows, request intake, row products and clip sums with visibility
// ----------------------------------------------------------------------------
module wtsp_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [wtsp_pkg::COEF_W-1:0]       i_pos_x,
    input  logic signed [wtsp_pkg::COEF_W-1:0]       i_pos_y,
    input  logic signed [wtsp_pkg::COEF_W-1:0]       i_pos_z,
    input  logic                                     i_cfg_we,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [wtsp_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                                     i_q_full,
    output logic                                     o_push,
    output wtsp_pkg::t_clip                          o_clip
);

    // lanes: 0 is row 0, 1 is row 1, 2 is the w row
    logic signed [wtsp_pkg::COEF_W-1:0] r_m [0:2][0:3];
    logic signed [wtsp_pkg::PROD_W-1:0] r_p [0:2][0:2];
    logic signed [wtsp_pkg::COEF_W-1:0] r_t [0:2];
    logic                               r_v1;
    logic                               r_v2;
    wtsp_pkg::t_clip                    r_clip;
    logic signed [wtsp_pkg::CLIP_W-1:0] n_sum [0:2];
    logic                               en;

    assign en      = !i_q_full;
    assign o_stall = i_q_full;
    assign o_push  = r_v2 && en;
    assign o_clip  = r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < 3; l++) begin
                for (int k = 0; k < 4; k++) begin
                    r_m[l][k] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            case (wtsp_pkg::t_reg_idx'(i_cfg_idx))
                wtsp_pkg::REG_ROW0_AB: begin
                    r_m[0][0] <= i_cfg_data[63:32];
                    r_m[0][1] <= i_cfg_data[31:0];
                end
                wtsp_pkg::REG_ROW0_CD: begin
                    r_m[0][2] <= i_cfg_data[63:32];
                    r_m[0][3] <= i_cfg_data[31:0];
                end
                wtsp_pkg::REG_ROW1_AB: begin
                    r_m[1][0] <= i_cfg_data[63:32];
                    r_m[1][1] <= i_cfg_data[31:0];
                end
                wtsp_pkg::REG_ROW1_CD: begin
                    r_m[1][2] <= i_cfg_data[63:32];
                    r_m[1][3] <= i_cfg_data[31:0];
                end
                wtsp_pkg::REG_ROW3_AB: begin
                    r_m[2][0] <= i_cfg_data[63:32];
                    r_m[2][1] <= i_cfg_data[31:0];
                end
                wtsp_pkg::REG_ROW3_CD: begin
                    r_m[2][2] <= i_cfg_data[63:32];
                    r_m[2][3] <= i_cfg_data[31:0];
                end
                // depth row has no effect on any result
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r_p[l][0] <= i_pos_x * r_m[l][0];
                r_p[l][1] <= i_pos_y * r_m[l][1];
                r_p[l][2] <= i_pos_z * r_m[l][2];
                r_t[l]    <= r_m[l][3];
            end
        end
    end

    // arithmetic shift of each product is the floor to q16.16
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sum[l] = wtsp_pkg::CLIP_W'($signed(r_p[l][0][wtsp_pkg::PROD_W-1:wtsp_pkg::FRAC_W]))
                     + wtsp_pkg::CLIP_W'($signed(r_p[l][1][wtsp_pkg::PROD_W-1:wtsp_pkg::FRAC_W]))
                     + wtsp_pkg::CLIP_W'($signed(r_p[l][2][wtsp_pkg::PROD_W-1:wtsp_pkg::FRAC_W]))
                     + wtsp_pkg::CLIP_W'(r_t[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clip.cx  <= n_sum[0];
            r_clip.cy  <= n_sum[1];
            r_clip.cw  <= n_sum[2];
            r_clip.vis <= (n_sum[2] >= wtsp_pkg::W_MIN);
        end
    end

endmodule

FILE: hdl/wtsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_queue
// short fifo of clip coordinates between front and back
// ----------------------------------------------------------------------------
module wtsp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wtsp_pkg::t_clip i_data,
    input  logic            i_pop,
    output wtsp_pkg::t_clip o_data,
    output logic            o_empty,
    output logic            o_full
);

    wtsp_pkg::t_clip          r_mem [0:wtsp_pkg::Q_DEPTH-1];
    logic [wtsp_pkg::Q_AW-1:0] r_wp;
    logic [wtsp_pkg::Q_AW-1:0] r_rp;
    logic [wtsp_pkg::Q_AW:0]   r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (wtsp_pkg::Q_AW+1)'(wtsp_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hdl/wtsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_back
// perspective divide, window mapping, saturation and result register
// ----------------------------------------------------------------------------
module wtsp_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wtsp_pkg::t_clip                      i_clip,
    input  logic                                 i_q_empty,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_visible,
    output logic signed [wtsp_pkg::OUT_W-1:0]    o_screen_x,
    output logic signed [wtsp_pkg::OUT_W-1:0]    o_screen_y
);

    localparam int CW = wtsp_pkg::CLIP_W;
    localparam int MW = wtsp_pkg::MAG_W;
    localparam int NW = wtsp_pkg::NUM_W;
    localparam int QW = wtsp_pkg::QUO_W;
    localparam int RW = wtsp_pkg::REM_W;
    localparam int SW = wtsp_pkg::SUM_W;

    localparam logic [MW-1:0] DIM_X = MW'(wtsp_pkg::SCREEN_WIDTH);
    localparam logic [MW-1:0] DIM_Y = MW'(wtsp_pkg::SCREEN_HEIGHT);
    localparam logic signed [SW-1:0] HALF_X = SW'(wtsp_pkg::SCREEN_WIDTH * 32768);
    localparam logic signed [SW-1:0] HALF_Y = SW'(wtsp_pkg::SCREEN_HEIGHT * 32768);
    localparam logic signed [SW-1:0] MAX32 = $signed({{(SW-32){1'b0}}, 32'h7fff_ffff});
    localparam logic signed [SW-1:0] MIN32 = $signed({{(SW-32){1'b1}}, 32'h8000_0000});
    localparam logic [QW-1:0] CAP_T = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic          neg;
        logic          cap;
        logic [RW-1:0] rem;
        logic [QW-1:0] nb;
        logic [QW-1:0] q;
    } t_lane;

    typedef struct packed {
        logic          vis;
        logic [CW-1:0] den;
        t_lane         lx;
        t_lane         ly;
    } t_dstage;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    function automatic t_lane div_step(input t_lane l, input logic [CW-1:0] den);
        logic [RW:0] trial;
        logic        ge;
        t_lane       o;
        trial = {l.rem, l.nb[QW-1]};
        ge    = (trial >= {1'b0, den});
        o     = l;
        o.rem = ge ? RW'(trial - {1'b0, den}) : RW'(trial);
        o.nb  = {l.nb[QW-2:0], 1'b0};
        o.q   = {l.q[QW-2:0], ge};
        return o;
    endfunction

    function automatic t_lane div_init(input logic [MW-1:0] mag, input logic neg,
                                       input logic [CW-1:0] den);
        logic [NW-1:0] num;
        t_lane         o;
        num   = (NW'(mag) << 15) + NW'(den >> 1);
        o.neg = neg;
        o.cap = (wtsp_pkg::CMP_W'(mag) >= {den, {wtsp_pkg::CAP_SH{1'b0}}});
        o.rem = RW'(num >> QW);
        o.nb  = num[QW-1:0];
        o.q   = '0;
        return o;
    endfunction

    function automatic logic signed [wtsp_pkg::OUT_W-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = v;
        if (v > MAX32) begin
            c = MAX32;
        end else if (v < MIN32) begin
            c = MIN32;
        end
        return c[wtsp_pkg::OUT_W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] signed_term(input t_lane l);
        logic [QW-1:0]        t;
        logic signed [SW-1:0] tv;
        t  = l.cap ? CAP_T : l.q;
        tv = $signed({3'b000, t});
        return l.neg ? -tv : tv;
    endfunction

    logic                 en;
    logic                 r0_v;
    logic                 r0_vis;
    logic [CW-1:0]        r0_den;
    logic [MW-1:0]        r0_mag_x;
    logic [MW-1:0]        r0_mag_y;
    logic                 r0_neg_x;
    logic                 r0_neg_y;
    logic                 r_sv [0:QW];
    t_dstage              r_s  [0:QW];
    logic                 r_ov;
    logic                 r_vis;
    logic signed [wtsp_pkg::OUT_W-1:0] r_sx;
    logic signed [wtsp_pkg::OUT_W-1:0] r_sy;
    logic [CW-1:0]        abs_x;
    logic [CW-1:0]        abs_y;

    assign en         = !r_ov || !i_stall;
    assign o_pop      = en && !i_q_empty;
    assign o_valid    = r_ov;
    assign o_visible  = r_vis;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;

    assign abs_x = i_clip.cx[CW-1] ? CW'(-i_clip.cx) : CW'(i_clip.cx);
    assign abs_y = i_clip.cy[CW-1] ? CW'(-i_clip.cy) : CW'(i_clip.cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r0_v    <= o_pop;
            r_sv[0] <= r0_v;
            for (int k = 0; k < QW; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_ov <= r_sv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_vis   <= i_clip.vis;
            r0_den   <= i_clip.cw;
            r0_neg_x <= i_clip.cx[CW-1];
            r0_neg_y <= i_clip.cy[CW-1];
            r0_mag_x <= MW'(abs_x[CW-2:0]) * DIM_X;
            r0_mag_y <= MW'(abs_y[CW-2:0]) * DIM_Y;

            r_s[0].vis <= r0_vis;
            r_s[0].den <= r0_den;
            r_s[0].lx  <= div_init(r0_mag_x, r0_neg_x, r0_den);
            r_s[0].ly  <= div_init(r0_mag_y, r0_neg_y, r0_den);

            for (int k = 0; k < QW; k++) begin
                r_s[k+1].vis <= r_s[k].vis;
                r_s[k+1].den <= r_s[k].den;
                r_s[k+1].lx  <= div_step(r_s[k].lx, r_s[k].den);
                r_s[k+1].ly  <= div_step(r_s[k].ly, r_s[k].den);
            end

            // not visible points report zero coordinates
            r_vis <= r_s[QW].vis;
            r_sx  <= r_s[QW].vis ? sat32(HALF_X + signed_term(r_s[QW].lx)) : '0;
            r_sy  <= r_s[QW].vis ? sat32(HALF_Y - signed_term(r_s[QW].ly)) : '0;
        end
    end

endmodule

FILE: hdl/world_to_screen_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection
// 4x4 view-projection of a world point to window pixels in q16.16
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  point     in         i_valid / o_stall    i_pos_x, i_pos_y, i_pos_z
//  result    out        o_valid / i_stall    o_visible, o_screen_x, o_screen_y
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data (64 bits)
//
//  one request per clock while the result side does not stall; a point reaches
//  o_valid through 42 registers (2 front stages, the first loaded at the accepting
//  edge, one queue slot, 2 setup stages, 36 stages of the radix-2 divider, one
//  output register); the divider resolves one quotient bit a stage
//  reset is synchronous and active low; it clears matrix, queue and valid bits
//  a stall on the result side freezes the back pipeline; the front keeps
//  taking requests until the four entry queue fills, then raises o_stall
// ----------------------------------------------------------------------------
module world_to_screen_projection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [31:0]                   i_pos_x,
    input  logic signed [31:0]                   i_pos_y,
    input  logic signed [31:0]                   i_pos_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_visible,
    output logic signed [31:0]                   o_screen_x,
    output logic signed [31:0]                   o_screen_y,
    input  logic                                 i_cfg_we,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wtsp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // clip coordinates between front and back
    wtsp_pkg::t_clip push_clip;
    wtsp_pkg::t_clip head_clip;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;

    // front: matrix rows, products, clip sums, visibility test
    wtsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_clip     (push_clip)
    );

    // queue lets the front keep going while the result side stalls
    wtsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_clip),
        .i_pop   (pop),
        .o_data  (head_clip),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back: divide by w, map to window, saturate, hold result
    wtsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clip     (head_clip),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_visible  (o_visible),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y)
    );

endmodule

FILE: hdl/wtsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsp_checker
// port level checks of the projection block
// ----------------------------------------------------------------------------
module wtsp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_visible,
    input logic signed [31:0]                o_screen_x,
    input logic signed [31:0]                o_screen_y
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_visible)
                               && $stable(o_screen_x) && $stable(o_screen_y))
        else $error("stalled result changed");

    // points with clip w below W_MIN (behind or too near the camera) report zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_visible |-> o_screen_x == 32'sd0 && o_screen_y == 32'sd0)
        else $error("hidden point with nonzero coordinates");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_visible  (o_visible),
    .o_screen_x (o_screen_x),
    .o_screen_y (o_screen_y)
);
